>>> rtl/pose_predict_3d_core_assert.svh
// Assertion macros used by the checker file pp3_core_chk.
`ifndef POSE_PREDICT_3D_CORE_ASSERT_SVH
`define POSE_PREDICT_3D_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PP3_ASSERT_NOW(lbl, clk, rstn, cond, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |-> (prop)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PP3_ASSERT_NXT(lbl, clk, rstn, cond, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |=> (prop)) \
        else $error(msg);

// Next-cycle implication that also checks across reset.
`define PP3_ASSERT_RST(lbl, clk, cond, prop, msg) \
    lbl: assert property (@(posedge clk) (cond) |=> (prop)) else $error(msg);

`endif

>>> rtl/pp3_pkg.sv
`default_nettype none
package pp3_pkg;

    localparam int unsigned CORDIC_STAGES_DEF = 24;

    // Angle widths: folded Q2.30 angle and CORDIC datapath
    localparam int unsigned ANG_W = 35;
    localparam int unsigned CW    = 34;

    localparam logic signed [ANG_W-1:0] PI_Q30      = 35'sd3373259426;
    localparam logic signed [ANG_W-1:0] TWO_PI_Q30  = 35'sd6746518852;
    localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 35'sd1686629713;
    localparam logic signed [CW-1:0]    K_Q30       = 34'sd652032874;
    localparam logic signed [42:0]      TWO_PI_Q28  = 43'sd1686629713;

    // Per-request data that rides alongside the datapath
    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
        logic signed [31:0] roll;
        logic signed [31:0] pitch;
        logic signed [31:0] yaw;
        logic signed [40:0] reach;
    } side_t;

    // Truncated Q2.30 arctangent of 2^-i
    function automatic logic signed [CW-1:0] atan_q30(input int unsigned idx);
        logic signed [CW-1:0] v;
        unique case (idx)
            0:  v = 34'sd843314856;
            1:  v = 34'sd497837829;
            2:  v = 34'sd263043836;
            3:  v = 34'sd133525158;
            4:  v = 34'sd67021686;
            5:  v = 34'sd33543515;
            6:  v = 34'sd16775850;
            7:  v = 34'sd8388437;
            8:  v = 34'sd4194282;
            9:  v = 34'sd2097149;
            10: v = 34'sd1048575;
            11: v = 34'sd524287;
            12: v = 34'sd262143;
            13: v = 34'sd131071;
            14: v = 34'sd65535;
            15: v = 34'sd32767;
            16: v = 34'sd16383;
            17: v = 34'sd8191;
            18: v = 34'sd4095;
            19: v = 34'sd2047;
            20: v = 34'sd1023;
            21: v = 34'sd511;
            22: v = 34'sd255;
            23: v = 34'sd127;
            24: v = 34'sd63;
            25: v = 34'sd31;
            26: v = 34'sd15;
            27: v = 34'sd7;
            28: v = 34'sd3;
            29: v = 34'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

    // Clamp to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
        logic signed [31:0] r;
        if (v > 48'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -48'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // Q2.30 times Q2.30, rounded back to Q2.30
    function automatic logic signed [CW-1:0] mul30(input logic signed [CW-1:0] a,
                                                   input logic signed [CW-1:0] b);
        logic signed [2*CW-1:0] p;
        p = a * b;
        p = p + (68'sd1 <<< 29);
        return p[CW+29:30];
    endfunction

endpackage
`default_nettype wire

>>> rtl/pose_predict_3d_core.sv
// Takes one request per cycle while the pipe advances; one CORDIC iteration per
// pipeline stage, three rotation lanes (roll, pitch, yaw) side by side.
// The whole pipe advances when the output register is empty or taken.
// Reset (aresetn low, synchronous) clears only the stage valid bits.
`default_nettype none
module pose_predict_3d_core #(
    parameter int unsigned CORDIC_STAGES = pp3_pkg::CORDIC_STAGES_DEF
) (
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                s_valid,
    output logic               s_ready,
    input  wire signed  [31:0] s_pos_x,
    input  wire signed  [31:0] s_pos_y,
    input  wire signed  [31:0] s_pos_z,
    input  wire signed  [31:0] s_roll_in,
    input  wire signed  [31:0] s_pitch_in,
    input  wire signed  [31:0] s_yaw_in,
    input  wire signed  [31:0] s_lin_speed,
    input  wire signed  [31:0] s_turn_rate,
    input  wire         [31:0] s_time_step,
    output logic               m_valid,
    input  wire                m_ready,
    output logic signed [31:0] m_next_x,
    output logic signed [31:0] m_next_y,
    output logic signed [31:0] m_next_z,
    output logic signed [31:0] m_next_roll,
    output logic signed [31:0] m_next_pitch,
    output logic signed [31:0] m_next_yaw
);
    import pp3_pkg::*;

    localparam int unsigned LAT = CORDIC_STAGES + 9;
    localparam int unsigned S_POST = CORDIC_STAGES + 2;

    logic                   adv;
    logic [LAT-1:0]         vld_reg;
    side_t                  side_reg [LAT];
    side_t                  side0_next;
    side_t                  side1_next;

    logic signed [ANG_W-1:0] ang_next [3];
    logic signed [ANG_W-1:0] ang_reg  [3];
    logic signed [64:0]      dv_prod;
    logic signed [64:0]      dw_prod;
    logic signed [64:0]      dv_rnd;
    logic signed [64:0]      dw_rnd;
    logic signed [40:0]      dyaw_reg;
    logic signed [42:0]      yaw_sum;

    logic signed [CW-1:0]    cx_reg [CORDIC_STAGES+1][3];
    logic signed [CW-1:0]    cy_reg [CORDIC_STAGES+1][3];
    logic signed [CW-1:0]    cz_reg [CORDIC_STAGES+1][3];
    logic                    neg_reg [CORDIC_STAGES+1][3];
    logic signed [CW-1:0]    z_next [3];
    logic                    neg_next [3];

    logic signed [CW-1:0]    sin_reg [3];
    logic signed [CW-1:0]    cos_reg [3];

    logic signed [CW-1:0]    cpcy_reg, crsy_reg, cysp_reg, srsy_reg, crcy_reg;
    logic signed [CW-1:0]    sr_a_reg, sp_a_reg;
    logic signed [CW-1:0]    hx_b_reg, t1_reg, t2_reg, t3_reg, t4_reg;
    logic signed [CW:0]      h_reg [3];
    logic signed [55:0]      ph_reg [3];
    logic signed [55:0]      pl_reg [3];
    logic signed [46:0]      off_reg [3];
    logic signed [31:0]      out_reg [3];

    // Advance the whole pipe unless the finished result is held
    assign adv     = !vld_reg[LAT-1] || m_ready;
    assign s_ready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[LAT-2:0], s_valid};
        end
    end

    // Stage 0: distance and yaw step products, first angle fold
    assign dv_prod = $signed({1'b0, s_time_step}) * s_lin_speed;
    assign dw_prod = $signed({1'b0, s_time_step}) * s_turn_rate;
    assign dv_rnd  = dv_prod + (65'sd1 <<< 23);
    assign dw_rnd  = dw_prod + (65'sd1 <<< 23);

    always_comb begin
        logic signed [ANG_W-1:0] a;
        logic signed [31:0]      src [3];
        src[0] = s_roll_in;
        src[1] = s_pitch_in;
        src[2] = s_yaw_in;
        for (int l = 0; l < 3; l++) begin
            a = {{(ANG_W-34){src[l][31]}}, src[l], 2'b00};
            if (a > PI_Q30) begin
                ang_next[l] = a - TWO_PI_Q30;
            end else if (a < -PI_Q30) begin
                ang_next[l] = a + TWO_PI_Q30;
            end else begin
                ang_next[l] = a;
            end
        end
        side0_next.px    = s_pos_x;
        side0_next.py    = s_pos_y;
        side0_next.pz    = s_pos_z;
        side0_next.roll  = s_roll_in;
        side0_next.pitch = s_pitch_in;
        side0_next.yaw   = s_yaw_in;
        side0_next.reach = dv_rnd[64:24];
    end

    // Stage 1: second fold into the CORDIC range, yaw update with wrap
    always_comb begin
        logic signed [ANG_W-1:0] a;
        for (int l = 0; l < 3; l++) begin
            a = ang_reg[l];
            if (a > HALF_PI_Q30) begin
                a           = a - PI_Q30;
                neg_next[l] = 1'b1;
            end else if (a < -HALF_PI_Q30) begin
                a           = a + PI_Q30;
                neg_next[l] = 1'b1;
            end else begin
                neg_next[l] = 1'b0;
            end
            z_next[l] = a[CW-1:0];
        end
        yaw_sum = {{11{side_reg[0].yaw[31]}}, side_reg[0].yaw}
                + {{2{dyaw_reg[40]}}, dyaw_reg};
        if (side_reg[0].yaw > 32'sd1686629713) begin
            yaw_sum = yaw_sum - TWO_PI_Q28;
        end else if (side_reg[0].yaw < 32'sd0) begin
            yaw_sum = yaw_sum + TWO_PI_Q28;
        end
        side1_next     = side_reg[0];
        side1_next.yaw = sat32({{5{yaw_sum[42]}}, yaw_sum});
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            ang_reg     <= ang_next;
            dyaw_reg    <= dw_rnd[64:24];
            side_reg[0] <= side0_next;
            side_reg[1] <= side1_next;
            for (int k = 2; k < LAT; k++) begin
                side_reg[k] <= side_reg[k-1];
            end
            for (int l = 0; l < 3; l++) begin
                cx_reg[0][l]  <= K_Q30;
                cy_reg[0][l]  <= '0;
                cz_reg[0][l]  <= z_next[l];
                neg_reg[0][l] <= neg_next[l];
            end
        end
    end

    // CORDIC rotation, one iteration per stage
    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
        localparam logic signed [CW-1:0] ATAN_I = atan_q30(i);
        always_ff @(posedge aclk) begin
            if (adv) begin
                for (int l = 0; l < 3; l++) begin
                    if (!cz_reg[i][l][CW-1]) begin
                        cx_reg[i+1][l] <= cx_reg[i][l] - (cy_reg[i][l] >>> i);
                        cy_reg[i+1][l] <= cy_reg[i][l] + (cx_reg[i][l] >>> i);
                        cz_reg[i+1][l] <= cz_reg[i][l] - ATAN_I;
                    end else begin
                        cx_reg[i+1][l] <= cx_reg[i][l] + (cy_reg[i][l] >>> i);
                        cy_reg[i+1][l] <= cy_reg[i][l] - (cx_reg[i][l] >>> i);
                        cz_reg[i+1][l] <= cz_reg[i][l] + ATAN_I;
                    end
                    neg_reg[i+1][l] <= neg_reg[i][l];
                end
            end
        end
    end

    // Heading vector and offsets
    always_ff @(posedge aclk) begin
        logic signed [76:0] full;
        if (adv) begin
            // negate both outputs for a half-turn fold
            for (int l = 0; l < 3; l++) begin
                if (neg_reg[CORDIC_STAGES][l]) begin
                    sin_reg[l] <= -cy_reg[CORDIC_STAGES][l];
                    cos_reg[l] <= -cx_reg[CORDIC_STAGES][l];
                end else begin
                    sin_reg[l] <= cy_reg[CORDIC_STAGES][l];
                    cos_reg[l] <= cx_reg[CORDIC_STAGES][l];
                end
            end
            // first products (lanes: 0 roll, 1 pitch, 2 yaw)
            cpcy_reg <= mul30(cos_reg[1], cos_reg[2]);
            crsy_reg <= mul30(cos_reg[0], sin_reg[2]);
            cysp_reg <= mul30(cos_reg[2], sin_reg[1]);
            srsy_reg <= mul30(sin_reg[0], sin_reg[2]);
            crcy_reg <= mul30(cos_reg[0], cos_reg[2]);
            sr_a_reg <= sin_reg[0];
            sp_a_reg <= sin_reg[1];
            // inner products
            hx_b_reg <= cpcy_reg;
            t1_reg   <= crsy_reg;
            t2_reg   <= mul30(cysp_reg, sr_a_reg);
            t3_reg   <= srsy_reg;
            t4_reg   <= mul30(crcy_reg, sp_a_reg);
            // heading terms
            h_reg[0] <= {hx_b_reg[CW-1], hx_b_reg};
            h_reg[1] <= {t1_reg[CW-1], t1_reg} + {t2_reg[CW-1], t2_reg};
            h_reg[2] <= {t3_reg[CW-1], t3_reg} - {t4_reg[CW-1], t4_reg};
            // split distance into high and low partial products
            for (int l = 0; l < 3; l++) begin
                ph_reg[l] <= $signed(side_reg[S_POST+3].reach[40:20]) * h_reg[l];
                pl_reg[l] <= $signed({1'b0, side_reg[S_POST+3].reach[19:0]}) * h_reg[l];
            end
            // recombine and round
            for (int l = 0; l < 3; l++) begin
                full = ({{21{ph_reg[l][55]}}, ph_reg[l]} <<< 20)
                     + {{21{pl_reg[l][55]}}, pl_reg[l]} + (77'sd1 <<< 29);
                off_reg[l] <= full[76:30];
            end
            // add to the position and clamp
            out_reg[0] <= sat32({{16{side_reg[S_POST+5].px[31]}}, side_reg[S_POST+5].px}
                              + {off_reg[0][46], off_reg[0]});
            out_reg[1] <= sat32({{16{side_reg[S_POST+5].py[31]}}, side_reg[S_POST+5].py}
                              + {off_reg[1][46], off_reg[1]});
            out_reg[2] <= sat32({{16{side_reg[S_POST+5].pz[31]}}, side_reg[S_POST+5].pz}
                              + {off_reg[2][46], off_reg[2]});
        end
    end

    assign m_valid      = vld_reg[LAT-1];
    assign m_next_x     = out_reg[0];
    assign m_next_y     = out_reg[1];
    assign m_next_z     = out_reg[2];
    assign m_next_roll  = side_reg[LAT-1].roll;
    assign m_next_pitch = side_reg[LAT-1].pitch;
    assign m_next_yaw   = side_reg[LAT-1].yaw;

endmodule
`default_nettype wire

>>> rtl/pp3_core_chk.sv
`default_nettype none
`include "pose_predict_3d_core_assert.svh"
module pp3_core_chk (
    input wire               aclk,
    input wire               aresetn,
    input wire               s_ready,
    input wire               m_valid,
    input wire               m_ready,
    input wire signed [31:0] m_next_x,
    input wire signed [31:0] m_next_y,
    input wire signed [31:0] m_next_z,
    input wire signed [31:0] m_next_yaw
);
    // Hold a stalled result
    `PP3_ASSERT_NXT(a_hold_valid, aclk, aresetn, m_valid && !m_ready, m_valid, "result dropped")
    `PP3_ASSERT_NXT(a_hold_data, aclk, aresetn, m_valid && !m_ready, $stable(m_next_x) && $stable(m_next_y) && $stable(m_next_z) && $stable(m_next_yaw), "result changed while stalled")
    // Accept a request whenever the output side can move
    `PP3_ASSERT_NOW(a_ready, aclk, aresetn, 1'b1, s_ready == (!m_valid || m_ready), "ready does not follow output side")
    // Drop all results on reset
    `PP3_ASSERT_RST(a_reset, aclk, !aresetn, !m_valid, "result valid after reset")
endmodule

bind pose_predict_3d_core pp3_core_chk u_pp3_core_chk (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .s_ready    (s_ready),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_next_x   (m_next_x),
    .m_next_y   (m_next_y),
    .m_next_z   (m_next_z),
    .m_next_yaw (m_next_yaw)
);
`default_nettype wire
